@@ hw/rtl/klrc_pkg.sv @@
package klrc_pkg;

  localparam int NUM_BANDS   = 8;
  localparam int NUM_GAINS   = 4;
  localparam int NUM_KNEES   = 5;
  localparam int TABLE_DEPTH = 1024;

  localparam int BAND_IW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int GAIN_W     = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int KNEE_W     = $clog2(NUM_KNEES);
  localparam int KNEE_SLOTS = NUM_BANDS * NUM_GAINS * NUM_KNEES;
  localparam int KADDR_W    = $clog2(KNEE_SLOTS);
  localparam int TIDX_W     = $clog2(TABLE_DEPTH);
  localparam int TABLE_SIZE = NUM_BANDS * TABLE_DEPTH;
  localparam int TADDR_W    = $clog2(TABLE_SIZE);
  // entry index wide enough for one past the last entry and for any truncated count
  localparam int E_W        = ((TIDX_W > 10) ? TIDX_W : 10) + 1;
  localparam int NUM_W      = E_W + 7;
  localparam int PROD_W     = 33 + NUM_W;
  localparam int DCNT_W     = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {
    OP_LOAD_KNEE = 2'd0,
    OP_SET_BAND  = 2'd1,
    OP_CONVERT   = 2'd2,
    OP_NOP       = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    RB_IDLE,
    RB_KREAD,
    RB_KWAIT,
    RB_SRCH,
    RB_SETUP,
    RB_MUL,
    RB_PREP,
    RB_DIV,
    RB_WR,
    RB_NEXTK
  } rb_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         band;
    logic [1:0]         gain_code;
    logic [2:0]         knee_index;
    logic [15:0]        knee_count;
    logic [31:0]        knee_radiance;
    logic [15:0]        dark_level;
    logic [23:0]        band_scale;
    logic signed [31:0] radiance_offset;
    logic [9:0]         raw_count;
    logic [23:0]        pixel_scale;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] radiance;
    logic [2:0]         out_band;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [KADDR_W-1:0] addr;
    logic [15:0]        count;
    logic [31:0]        rad;
  } knee_wr_t;

  typedef struct packed {
    logic               go;
    logic [BAND_IW-1:0] band;
    logic [GAIN_W-1:0]  gain;
  } rb_start_t;

  typedef struct packed {
    logic               we;
    logic [TADDR_W-1:0] addr;
    logic [31:0]        data;
  } tab_wr_t;

  typedef struct packed {
    logic               we;
    logic [BAND_IW-1:0] band;
    logic [15:0]        dark;
    logic [23:0]        scale;
    logic signed [31:0] offset;
  } band_wr_t;

  typedef struct packed {
    logic               valid;
    logic [BAND_IW-1:0] band;
    logic [2:0]         band_tag;
    logic [9:0]         raw;
    logic [23:0]        pxs;
  } conv_req_t;

  // telemetry gain code to table gain: swap the two bits
  function automatic logic [1:0] remap_gain(input logic [1:0] code);
    return {code[0], code[1]};
  endfunction

endpackage

@@ hw/rtl/klrc_ram.sv @@
module klrc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ hw/rtl/klrc_rebuild.sv @@
module klrc_rebuild (
  input  logic                clk,
  input  logic                rst,
  input  klrc_pkg::knee_wr_t  knee_wr,
  input  klrc_pkg::rb_start_t go,
  output logic                busy,
  output klrc_pkg::tab_wr_t   tab_wr
);
  import klrc_pkg::*;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] rad;
  } knee_t;

  knee_t              kmem [KNEE_SLOTS];
  knee_t              kdata;
  logic [KADDR_W-1:0] raddr;

  rb_state_t          state, state_next;
  logic [KADDR_W-1:0] kbase;
  logic [TADDR_W-1:0] tbase;
  logic [KNEE_W-1:0]  k, j;
  logic [15:0]        ck, cp;
  logic [31:0]        rk, rp;
  logic [E_W-1:0]     e, last;
  logic               dzero, neg;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]  quo;
  logic [16:0]        rem;
  logic [15:0]        dv;
  logic [DCNT_W-1:0]  cnt;

  logic               srch_done;
  logic [E_W-1:0]     first_c, last_c, trunc_k;
  logic signed [16:0] dc;
  logic signed [NUM_W-1:0]  num;
  logic signed [32:0] dr;
  logic signed [PROD_W-1:0] prod_c;
  logic [16:0]        rem_sh;
  logic signed [PROD_W:0]   qs;
  logic signed [PROD_W+1:0] val;
  logic [31:0]        sat;

  always_ff @(posedge clk) begin
    if (knee_wr.we) begin
      kmem[knee_wr.addr] <= '{count: knee_wr.count, rad: knee_wr.rad};
    end
    kdata <= kmem[raddr];
  end

  // previous knee search ends on a different whole count or at knee zero
  assign srch_done = (kdata.count[15:6] != ck[15:6]) || (j == '0);
  assign first_c   = (k == KNEE_W'(1)) ? '0 : E_W'(cp[15:6]) + E_W'(1);
  assign trunc_k   = E_W'(ck[15:6]);
  assign last_c    = ((k == KNEE_W'(NUM_KNEES - 1)) || (trunc_k > E_W'(TABLE_DEPTH - 1))) ?
                     E_W'(TABLE_DEPTH - 1) : trunc_k;
  assign dc        = $signed({1'b0, ck}) - $signed({1'b0, cp});
  assign num       = $signed({1'b0, e, 6'b0}) - $signed(NUM_W'(cp));
  assign dr        = $signed({1'b0, rk}) - $signed({1'b0, rp});
  assign prod_c    = PROD_W'(dr) * PROD_W'(num);
  assign rem_sh    = {rem[15:0], quo[PROD_W-1]};
  assign qs        = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign val       = $signed({(PROD_W - 30)'(0), rp}) + (PROD_W + 2)'(qs);

  always_comb begin
    if (dzero) begin
      sat = rp;
    end else if (val[PROD_W+1]) begin
      sat = '0;
    end else if (|val[PROD_W:32]) begin
      sat = '1;
    end else begin
      sat = val[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      RB_IDLE:  if (go.go) state_next = RB_KREAD;
      RB_KREAD: state_next = RB_KWAIT;
      RB_KWAIT: state_next = RB_SRCH;
      RB_SRCH:  if (srch_done) state_next = RB_SETUP;
      RB_SETUP: state_next = (first_c > last_c) ? RB_NEXTK : RB_MUL;
      RB_MUL:   state_next = dzero ? RB_WR : RB_PREP;
      RB_PREP:  state_next = RB_DIV;
      RB_DIV:   if (cnt == DCNT_W'(1)) state_next = RB_WR;
      RB_WR:    state_next = (e == last) ? RB_NEXTK : RB_MUL;
      RB_NEXTK: state_next = (k == KNEE_W'(NUM_KNEES - 1)) ? RB_IDLE : RB_KREAD;
      default:  state_next = RB_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != RB_IDLE);
    tab_wr.we   = (state == RB_WR);
    tab_wr.addr = tbase + TADDR_W'(e[TIDX_W-1:0]);
    tab_wr.data = sat;
    unique case (state)
      RB_KREAD: raddr = kbase + KADDR_W'(k);
      RB_KWAIT: raddr = kbase + KADDR_W'(k) - KADDR_W'(1);
      RB_SRCH:  raddr = kbase + KADDR_W'(j) - KADDR_W'(1);
      default:  raddr = kbase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RB_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      RB_IDLE: begin
        kbase <= KADDR_W'((int'(go.band) * NUM_GAINS + int'(go.gain)) * NUM_KNEES);
        tbase <= TADDR_W'(int'(go.band) * TABLE_DEPTH);
        k     <= KNEE_W'(1);
      end
      RB_KWAIT: begin
        ck <= kdata.count;
        rk <= kdata.rad;
        j  <= k - KNEE_W'(1);
      end
      RB_SRCH: begin
        cp <= kdata.count;
        rp <= kdata.rad;
        if (!srch_done) begin
          j <= j - KNEE_W'(1);
        end
      end
      RB_SETUP: begin
        e     <= first_c;
        last  <= last_c;
        dzero <= (ck == cp);
      end
      RB_MUL: begin
        prod <= prod_c;
      end
      RB_PREP: begin
        quo <= prod[PROD_W-1] ? PROD_W'(-prod) : prod;
        neg <= prod[PROD_W-1] ^ dc[16];
        dv  <= dc[16] ? 16'(-dc) : dc[15:0];
        rem <= '0;
        cnt <= DCNT_W'(PROD_W);
      end
      RB_DIV: begin
        // one quotient bit per cycle
        if (rem_sh >= {1'b0, dv}) begin
          rem <= rem_sh - {1'b0, dv};
          quo <= {quo[PROD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt - DCNT_W'(1);
      end
      RB_WR: begin
        e <= e + E_W'(1);
      end
      RB_NEXTK: begin
        k <= k + KNEE_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/klrc_convert.sv @@
module klrc_convert (
  input  logic                        clk,
  input  logic                        rst,
  input  klrc_pkg::band_wr_t          band_wr,
  input  klrc_pkg::conv_req_t         req,
  output logic [klrc_pkg::TADDR_W-1:0] raddr0,
  output logic [klrc_pkg::TADDR_W-1:0] raddr1,
  input  logic [31:0]                 t0,
  input  logic [31:0]                 t1,
  output logic                        strobe,
  output klrc_pkg::result_t           result
);
  import klrc_pkg::*;

  logic [15:0]        band_dark  [NUM_BANDS];
  logic [23:0]        band_scale [NUM_BANDS];
  logic signed [31:0] band_off   [NUM_BANDS];

  logic [15:0]        d;
  logic [16:0]        dsum;
  logic [10:0]        dark;
  logic [5:0]         fr;
  logic signed [12:0] lo_s;
  logic [12:0]        lo_c;
  logic [TIDX_W-1:0]  lo_idx;
  logic [TADDR_W-1:0] row;

  logic               s1_v, s2_v, s3_v;
  logic [2:0]         s1_b, s2_b, s3_b;
  logic [5:0]         s1_fr;
  logic [23:0]        s1_sc, s2_sc, s1_px, s2_px, s3_px;
  logic signed [31:0] s1_off, s2_off, s3_off, s4_off;
  logic [31:0]        v1;
  logic [35:0]        v2;
  logic [39:0]        v3;
  logic               s4_v;
  logic [2:0]         s4_b;

  logic [38:0]        blend;
  logic [55:0]        m2;
  logic [59:0]        m3;
  logic signed [41:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_dark[i]  <= '0;
        band_scale[i] <= '0;
        band_off[i]   <= '0;
      end
    end else if (band_wr.we) begin
      band_dark[band_wr.band]  <= band_wr.dark;
      band_scale[band_wr.band] <= band_wr.scale;
      band_off[band_wr.band]   <= band_wr.offset;
    end
  end

  // dark level rounded up to whole counts; fraction is what the rounding added
  assign d      = band_dark[req.band];
  assign dsum   = {1'b0, d} + 17'd63;
  assign dark   = dsum[16:6];
  assign fr     = 6'(7'd64 - {1'b0, d[5:0]});
  assign lo_s   = $signed({3'b0, req.raw}) - $signed({2'b0, dark});

  always_comb begin
    if (lo_s < 0) begin
      lo_c = '0;
    end else if (lo_s > $signed(13'(TABLE_DEPTH - 2))) begin
      lo_c = 13'(TABLE_DEPTH - 2);
    end else begin
      lo_c = lo_s;
    end
  end

  assign lo_idx = TIDX_W'(lo_c);
  assign row    = TADDR_W'(int'(req.band) * TABLE_DEPTH);
  assign raddr0 = row + TADDR_W'(lo_idx);
  assign raddr1 = row + TADDR_W'(lo_idx) + TADDR_W'(1);

  assign blend = 39'(t0) * 39'(7'd64 - {1'b0, s1_fr}) + 39'(t1) * 39'(s1_fr);
  assign m2    = 56'(v1) * 56'(s2_sc);
  assign m3    = 60'(v2) * 60'(s3_px);
  assign sum   = $signed({2'b0, v3}) + 42'(s4_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      s4_v   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      s1_v   <= req.valid;
      s2_v   <= s1_v;
      s3_v   <= s2_v;
      s4_v   <= s3_v;
      strobe <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_b   <= req.band_tag;
    s1_fr  <= fr;
    s1_sc  <= band_scale[req.band];
    s1_px  <= req.pxs;
    s1_off <= band_off[req.band];

    v1     <= blend[37:6];
    s2_b   <= s1_b;
    s2_sc  <= s1_sc;
    s2_px  <= s1_px;
    s2_off <= s1_off;

    v2     <= m2[55:20];
    s3_b   <= s2_b;
    s3_px  <= s2_px;
    s3_off <= s2_off;

    v3     <= m3[59:20];
    s4_b   <= s3_b;
    s4_off <= s3_off;

    result.out_band <= s4_b;
    if (!sum[41] && (|sum[40:31])) begin
      result.radiance <= 32'sh7FFF_FFFF;
    end else if (sum[41] && !(&sum[40:31])) begin
      result.radiance <= 32'sh8000_0000;
    end else begin
      result.radiance <= sum[31:0];
    end
  end

endmodule

@@ hw/rtl/knee_lut_radiance_calibrator.sv @@
// Knee-table radiance calibrator. A word is taken when start is high and busy
// is low. A pixel conversion enters every cycle while busy is low, and its
// radiance appears on result with strobe high for one cycle after it passes
// the table read and the blend, band-scale, pixel-scale and offset stages; the
// receiver cannot stall, so results must be taken as they come. A band setting
// that changes the gain, follows knee reloads, or is the first for its band
// rebuilds that band's table: busy stays high while knees are read for each
// segment and the one-bit-per-cycle divider computes each interpolated entry.
// Tables are not cleared at reset; a band must be set before its pixels are
// converted.
module knee_lut_radiance_calibrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  klrc_pkg::in_item_t item,
  output logic               strobe,
  output klrc_pkg::result_t  result
);
  import klrc_pkg::*;

  logic [GAIN_W-1:0]  band_gain [NUM_BANDS];
  logic [NUM_BANDS-1:0] table_valid, knees_dirty;

  logic               accept, band_ok, gain_ok, knee_ok, need_rb;
  logic [1:0]         g;
  logic [BAND_IW-1:0] bi;
  logic [GAIN_W-1:0]  gi;

  knee_wr_t           knee_wr;
  rb_start_t          rb_go;
  tab_wr_t            tab_wr;
  band_wr_t           band_wr;
  conv_req_t          req;
  logic [TADDR_W-1:0] raddr0, raddr1;
  logic [31:0]        t0, t1;

  assign accept  = start && !busy;
  assign band_ok = int'(item.band) < NUM_BANDS;
  assign g       = remap_gain(item.gain_code);
  assign gain_ok = int'(g) < NUM_GAINS;
  assign knee_ok = int'(item.knee_index) < NUM_KNEES;
  assign bi      = BAND_IW'(item.band);
  assign gi      = GAIN_W'(g);
  assign need_rb = !table_valid[bi] || (band_gain[bi] != gi) || knees_dirty[bi];

  always_comb begin
    knee_wr.we    = accept && (item.opcode == OP_LOAD_KNEE) && band_ok && gain_ok && knee_ok;
    knee_wr.addr  = KADDR_W'((int'(item.band) * NUM_GAINS + int'(g)) * NUM_KNEES
                             + int'(item.knee_index));
    knee_wr.count = item.knee_count;
    knee_wr.rad   = item.knee_radiance;

    band_wr.we     = accept && (item.opcode == OP_SET_BAND) && band_ok && gain_ok;
    band_wr.band   = bi;
    band_wr.dark   = item.dark_level;
    band_wr.scale  = item.band_scale;
    band_wr.offset = item.radiance_offset;

    rb_go.go   = band_wr.we && need_rb;
    rb_go.band = bi;
    rb_go.gain = gi;

    req.valid    = accept && (item.opcode == OP_CONVERT) && band_ok;
    req.band     = bi;
    req.band_tag = item.band;
    req.raw      = item.raw_count;
    req.pxs      = item.pixel_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_gain[i] <= '0;
      end
      table_valid <= '0;
      knees_dirty <= '0;
    end else begin
      if (knee_wr.we) begin
        knees_dirty[bi] <= 1'b1;
      end
      if (rb_go.go) begin
        band_gain[bi]   <= gi;
        table_valid[bi] <= 1'b1;
        knees_dirty[bi] <= 1'b0;
      end
    end
  end

  klrc_rebuild u_rebuild (
    .clk     (clk),
    .rst     (rst),
    .knee_wr (knee_wr),
    .go      (rb_go),
    .busy    (busy),
    .tab_wr  (tab_wr)
  );

  klrc_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (32)
  ) u_table (
    .clk    (clk),
    .we     (tab_wr.we),
    .waddr  (tab_wr.addr),
    .wdata  (tab_wr.data),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (t0),
    .rdata1 (t1)
  );

  klrc_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .band_wr (band_wr),
    .req     (req),
    .raddr0  (raddr0),
    .raddr1  (raddr1),
    .t0      (t0),
    .t1      (t1),
    .strobe  (strobe),
    .result  (result)
  );

endmodule
